// ----- design/qste_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qste_pkg
// Shared types and constants of the smallest-three quaternion encoder.
// ----------------------------------------------------------------------------
package qste_pkg;

    // Fixed-point format of the quaternion components
    localparam int FRAC_BITS     = 16;
    localparam int IN_W          = 18;
    localparam int MAG_W         = IN_W;
    localparam int V_W           = IN_W + 1;

    // Codes
    localparam int MAX_CODE_BITS = 16;
    localparam int CODE_W        = 16;
    localparam int N_W           = 5;
    localparam int MAIN_W        = 32;
    localparam int EXTRA_W       = 16;
    localparam int IDX_W         = 2;
    localparam int MIN_CODE_BITS = 2;

    // Code widths of the fixed packed layouts
    localparam int W_FMT9        = 9;
    localparam int W_FMT10       = 10;
    localparam int W_FMT15       = 15;

    // Quantizer bound B = 46341/65536, scaled to the component format
    localparam longint unsigned BOUND_Q16 = 64'd46341;
    localparam int IN_SHL  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam longint unsigned OFFSET = (FRAC_BITS >= 16) ?
                                         (BOUND_Q16 << (FRAC_BITS - 16)) : BOUND_Q16;
    localparam longint unsigned DEN    = 2 * OFFSET;
    localparam int DEN_W   = $clog2(DEN);
    localparam int A_W     = (((V_W + IN_SHL) > (DEN_W + 1)) ?
                              (V_W + IN_SHL) : (DEN_W + 1)) + 1;

    // Rounded division by DEN through a reciprocal with one correction step
    localparam int NUM_W   = DEN_W + MAX_CODE_BITS;
    localparam longint unsigned RECIP = (64'd1 << NUM_W) / DEN;
    localparam int RCP_W   = MAX_CODE_BITS + 2;
    localparam int REM_W   = DEN_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_BITS   = 1'b0,
        CFG_PACK_FORMAT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PACK_NONE = 2'd0,
        PACK_W9   = 2'd1,
        PACK_W10  = 2'd2,
        PACK_W15  = 2'd3
    } t_pack_fmt;

    localparam logic [N_W-1:0] RST_CODE_BITS = N_W'(9);

    // Per-lane pipeline control
    typedef struct packed {
        logic           en3;
        logic           en4;
        logic           en5;
        logic [N_W-1:0] n;
    } t_lane_ctrl;

endpackage
`default_nettype wire

// ----- design/qste_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qste_if
// Valid/ready channels carrying quaternion words in and encoded words out.
// ----------------------------------------------------------------------------
interface qste_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qste_pkg::IN_W-1:0]    comp_x;
    logic signed [qste_pkg::IN_W-1:0]    comp_y;
    logic signed [qste_pkg::IN_W-1:0]    comp_z;
    logic signed [qste_pkg::IN_W-1:0]    comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface qste_out_if;
    logic                                valid;
    logic                                ready;
    logic [qste_pkg::CODE_W-1:0]         code_first;
    logic [qste_pkg::CODE_W-1:0]         code_second;
    logic [qste_pkg::CODE_W-1:0]         code_third;
    logic [qste_pkg::IDX_W-1:0]          dropped_index;
    logic                                largest_positive;
    logic [qste_pkg::MAIN_W-1:0]         packed_main;
    logic [qste_pkg::EXTRA_W-1:0]        packed_extra;

    modport source (output valid, code_first, code_second, code_third, dropped_index,
                    largest_positive, packed_main, packed_extra, input ready);
    modport sink   (input valid, code_first, code_second, code_third, dropped_index,
                    largest_positive, packed_main, packed_extra, output ready);
endinterface
`default_nettype wire

// ----- design/qste_quant.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qste_quant
// One quantizer lane: code = round(a * (2^n - 1) / DEN), three stages deep.
// ----------------------------------------------------------------------------
module qste_quant (
    input  wire logic                              i_clk,
    input  wire qste_pkg::t_lane_ctrl              i_ctrl,
    input  wire logic [qste_pkg::DEN_W-1:0]        i_a,
    input  wire logic                              i_zero,
    input  wire logic                              i_sat,
    output logic [qste_pkg::CODE_W-1:0]            o_code
);

    localparam int MW1  = qste_pkg::MAX_CODE_BITS + 1;
    localparam int PR_W = qste_pkg::NUM_W + qste_pkg::RCP_W;

    logic [MW1-1:0]                       m_full;
    logic [qste_pkg::NUM_W-1:0]           n_num;
    logic [PR_W-1:0]                      n_prod;
    logic [qste_pkg::NUM_W-1:0]           n_qd;
    logic [qste_pkg::REM_W-1:0]           rem;

    logic [qste_pkg::NUM_W-1:0]           r3_num;
    logic                                 r3_zero, r3_sat;
    logic [qste_pkg::CODE_W-1:0]          r3_m;

    logic [qste_pkg::CODE_W-1:0]          r4_q0;
    logic [qste_pkg::REM_W-1:0]           r4_num;
    logic                                 r4_zero, r4_sat;
    logic [qste_pkg::CODE_W-1:0]          r4_m;

    logic [qste_pkg::CODE_W-1:0]          r5_q0;
    logic [qste_pkg::REM_W-1:0]           r5_num;
    logic [qste_pkg::REM_W-1:0]           r5_qd;
    logic                                 r5_zero, r5_sat;
    logic [qste_pkg::CODE_W-1:0]          r5_m;

    // a * m + DEN/2 with m = 2^n - 1 done as shift and subtract
    assign m_full = (MW1'(1) << i_ctrl.n) - MW1'(1);
    assign n_num  = (qste_pkg::NUM_W'(i_a) << i_ctrl.n) - qste_pkg::NUM_W'(i_a)
                    + qste_pkg::NUM_W'(qste_pkg::OFFSET);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r3_num  <= n_num;
            r3_zero <= i_zero;
            r3_sat  <= i_sat;
            r3_m    <= m_full[qste_pkg::CODE_W-1:0];
        end
    end

    // Estimate quotient; it is the exact one or one short
    assign n_prod = PR_W'(r3_num) * PR_W'(qste_pkg::RCP_W'(qste_pkg::RECIP));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en4) begin
            r4_q0   <= n_prod[qste_pkg::NUM_W +: qste_pkg::CODE_W];
            r4_num  <= r3_num[qste_pkg::REM_W-1:0];
            r4_zero <= r3_zero;
            r4_sat  <= r3_sat;
            r4_m    <= r3_m;
        end
    end

    assign n_qd = qste_pkg::NUM_W'(r4_q0) * qste_pkg::NUM_W'(qste_pkg::DEN);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en5) begin
            r5_q0   <= r4_q0;
            r5_num  <= r4_num;
            r5_qd   <= n_qd[qste_pkg::REM_W-1:0];
            r5_zero <= r4_zero;
            r5_sat  <= r4_sat;
            r5_m    <= r4_m;
        end
    end

    // Remainder below 2*DEN: one compare settles the quotient
    assign rem = r5_num - r5_qd;

    always_comb begin
        if (r5_zero) begin
            o_code = '0;
        end else if (r5_sat) begin
            o_code = r5_m;
        end else if (rem >= qste_pkg::REM_W'(qste_pkg::DEN)) begin
            o_code = r5_q0 + qste_pkg::CODE_W'(1);
        end else begin
            o_code = r5_q0;
        end
    end

endmodule
`default_nettype wire

// ----- design/quaternion_smallest_three_encoder_unit.sv -----
// A word taken into the stage 1 registers moves on through the stage 2 to stage 6
// registers in order and waits in the output register until it is taken.
// Throughput: one word per cycle unless the output stalls; six register stages,
// each moving on its own ready. A stalled output only blocks stages that hold data,
// so bubbles still fill. Reset (synchronous, active low) empties the pipeline
// and sets code_bits to 9 and pack_format to the nine-bit word layout.
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_smallest_three_encoder_unit
// Smallest-three encoder for unit quaternions: drops the largest component,
// quantizes the other three and packs them into the selected word layout, if any.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_encoder_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [qste_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qste_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    qste_in_if.sink                                 i_in,
    qste_out_if.source                              o_out
);

    localparam int NST = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [qste_pkg::N_W-1:0]   r_code_bits;
    qste_pkg::t_pack_fmt        r_pack_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits   <= qste_pkg::RST_CODE_BITS;
            r_pack_format <= qste_pkg::PACK_W9;
        end else if (i_cfg_we) begin
            case (qste_pkg::t_cfg_idx'(i_cfg_idx))
                qste_pkg::CFG_CODE_BITS: begin
                    r_code_bits <= i_cfg_data[qste_pkg::N_W-1:0];
                end
                qste_pkg::CFG_PACK_FORMAT: begin
                    r_pack_format <= qste_pkg::t_pack_fmt'(i_cfg_data[1:0]);
                end
                default: begin
                    r_code_bits <= r_code_bits;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage advances when empty or when the next
    // one advances. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [NST:1]   r_vld;
    logic [NST+1:1] en;

    always_comb begin
        en[NST+1] = o_out.ready;
        for (int k = NST; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready  = en[1];
    assign o_out.valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: find the largest magnitude (lowest index wins a tie),
    // its sign, and the active code width.
    // ------------------------------------------------------------------
    logic signed [qste_pkg::IN_W-1:0]  s1_comp [4];
    logic [qste_pkg::MAG_W-1:0]        s1_mag  [4];
    logic                              s1_sel01, s1_sel23, s1_pick;
    logic [qste_pkg::MAG_W-1:0]        s1_m01, s1_m23;
    logic [qste_pkg::IDX_W-1:0]        s1_idx;
    logic [qste_pkg::N_W-1:0]          s1_n;

    assign s1_comp[0] = i_in.comp_x;
    assign s1_comp[1] = i_in.comp_y;
    assign s1_comp[2] = i_in.comp_z;
    assign s1_comp[3] = i_in.comp_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // most negative input maps to 2^17, still fits unsigned
            s1_mag[i] = s1_comp[i][qste_pkg::IN_W-1] ?
                        (~s1_comp[i] + qste_pkg::MAG_W'(1)) : s1_comp[i];
        end
        s1_sel01 = s1_mag[1] > s1_mag[0];
        s1_sel23 = s1_mag[3] > s1_mag[2];
        s1_m01   = s1_sel01 ? s1_mag[1] : s1_mag[0];
        s1_m23   = s1_sel23 ? s1_mag[3] : s1_mag[2];
        s1_pick  = s1_m23 > s1_m01;
        s1_idx   = s1_pick ? {1'b1, s1_sel23} : {1'b0, s1_sel01};
    end

    always_comb begin
        case (r_pack_format)
            qste_pkg::PACK_W9:  s1_n = qste_pkg::N_W'(qste_pkg::W_FMT9);
            qste_pkg::PACK_W10: s1_n = qste_pkg::N_W'(qste_pkg::W_FMT10);
            qste_pkg::PACK_W15: s1_n = qste_pkg::N_W'(qste_pkg::W_FMT15);
            default: begin
                // fields only: clamp the programmed width
                if (r_code_bits < qste_pkg::N_W'(qste_pkg::MIN_CODE_BITS)) begin
                    s1_n = qste_pkg::N_W'(qste_pkg::MIN_CODE_BITS);
                end else if (r_code_bits > qste_pkg::N_W'(qste_pkg::MAX_CODE_BITS)) begin
                    s1_n = qste_pkg::N_W'(qste_pkg::MAX_CODE_BITS);
                end else begin
                    s1_n = r_code_bits;
                end
            end
        endcase
    end

    logic signed [qste_pkg::IN_W-1:0]  r1_comp [4];
    logic [qste_pkg::IDX_W-1:0]        r1_idx;
    logic                              r1_sign;
    logic [qste_pkg::N_W-1:0]          r1_n;
    qste_pkg::t_pack_fmt               r1_fmt;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 4; i++) begin
                r1_comp[i] <= s1_comp[i];
            end
            r1_idx  <= s1_idx;
            // zero counts as non-negative
            r1_sign <= !s1_comp[s1_idx][qste_pkg::IN_W-1];
            r1_n    <= s1_n;
            r1_fmt  <= r_pack_format;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: take the three kept components in index order, negate them
    // when the dropped one is negative, and add the bound offset.
    // ------------------------------------------------------------------
    logic signed [qste_pkg::IN_W-1:0]  s2_keep [3];
    logic signed [qste_pkg::V_W-1:0]   s2_v    [3];
    logic signed [qste_pkg::A_W-1:0]   s2_a    [3];
    logic                              s2_zero [3];
    logic                              s2_sat  [3];

    always_comb begin
        s2_keep[0] = (r1_idx == qste_pkg::IDX_W'(0)) ? r1_comp[1] : r1_comp[0];
        s2_keep[1] = (r1_idx <= qste_pkg::IDX_W'(1)) ? r1_comp[2] : r1_comp[1];
        s2_keep[2] = (r1_idx == qste_pkg::IDX_W'(3)) ? r1_comp[2] : r1_comp[3];
        for (int j = 0; j < 3; j++) begin
            s2_v[j]    = r1_sign ? qste_pkg::V_W'(s2_keep[j]) : -qste_pkg::V_W'(s2_keep[j]);
            s2_a[j]    = (qste_pkg::A_W'(s2_v[j]) <<< qste_pkg::IN_SHL)
                         + qste_pkg::A_W'(qste_pkg::OFFSET);
            s2_zero[j] = s2_a[j][qste_pkg::A_W-1] || (s2_a[j] == '0);
            s2_sat[j]  = !s2_a[j][qste_pkg::A_W-1] &&
                         (s2_a[j] >= qste_pkg::A_W'(qste_pkg::DEN));
        end
    end

    logic [qste_pkg::DEN_W-1:0]        r2_a    [3];
    logic                              r2_zero [3];
    logic                              r2_sat  [3];
    logic [qste_pkg::IDX_W-1:0]        r2_idx;
    logic                              r2_sign;
    logic [qste_pkg::N_W-1:0]          r2_n;
    qste_pkg::t_pack_fmt               r2_fmt;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int j = 0; j < 3; j++) begin
                r2_a[j]    <= s2_a[j][qste_pkg::DEN_W-1:0];
                r2_zero[j] <= s2_zero[j];
                r2_sat[j]  <= s2_sat[j];
            end
            r2_idx  <= r1_idx;
            r2_sign <= r1_sign;
            r2_n    <= r1_n;
            r2_fmt  <= r1_fmt;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: three quantizer lanes; side data rides alongside.
    // ------------------------------------------------------------------
    qste_pkg::t_lane_ctrl          lane_ctrl;
    logic [qste_pkg::CODE_W-1:0]   lane_code [3];

    assign lane_ctrl.en3 = en[3];
    assign lane_ctrl.en4 = en[4];
    assign lane_ctrl.en5 = en[5];
    assign lane_ctrl.n   = r2_n;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        qste_quant u_quant (
            .i_clk  (i_clk),
            .i_ctrl (lane_ctrl),
            .i_a    (r2_a[j]),
            .i_zero (r2_zero[j]),
            .i_sat  (r2_sat[j]),
            .o_code (lane_code[j])
        );
    end

    logic [qste_pkg::IDX_W-1:0]   r3_idx, r4_idx, r5_idx;
    logic                         r3_sign, r4_sign, r5_sign;
    qste_pkg::t_pack_fmt          r3_fmt, r4_fmt, r5_fmt;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_idx  <= r2_idx;
            r3_sign <= r2_sign;
            r3_fmt  <= r2_fmt;
        end
        if (en[4]) begin
            r4_idx  <= r3_idx;
            r4_sign <= r3_sign;
            r4_fmt  <= r3_fmt;
        end
        if (en[5]) begin
            r5_idx  <= r4_idx;
            r5_sign <= r4_sign;
            r5_fmt  <= r4_fmt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pack the word layout and hold the result for the sink.
    // ------------------------------------------------------------------
    logic [qste_pkg::MAIN_W-1:0]  n_main;
    logic [qste_pkg::EXTRA_W-1:0] n_extra;

    always_comb begin
        n_main  = '0;
        n_extra = '0;
        case (r5_fmt)
            qste_pkg::PACK_W9: begin
                n_main = {1'b0, r5_sign, 1'b0, r5_idx,
                          lane_code[2][qste_pkg::W_FMT9-1:0],
                          lane_code[1][qste_pkg::W_FMT9-1:0],
                          lane_code[0][qste_pkg::W_FMT9-1:0]};
            end
            qste_pkg::PACK_W10: begin
                n_main = {r5_idx,
                          lane_code[2][qste_pkg::W_FMT10-1:0],
                          lane_code[1][qste_pkg::W_FMT10-1:0],
                          lane_code[0][qste_pkg::W_FMT10-1:0]};
            end
            qste_pkg::PACK_W15: begin
                n_main  = {r5_idx,
                           lane_code[1][qste_pkg::W_FMT15-1:0],
                           lane_code[0][qste_pkg::W_FMT15-1:0]};
                n_extra = {r5_sign, lane_code[2][qste_pkg::W_FMT15-1:0]};
            end
            default: begin
                // fields only: packed words stay zero
                n_main  = '0;
                n_extra = '0;
            end
        endcase
    end

    logic [qste_pkg::CODE_W-1:0]  r6_code [3];
    logic [qste_pkg::IDX_W-1:0]   r6_idx;
    logic                         r6_sign;
    logic [qste_pkg::MAIN_W-1:0]  r6_main;
    logic [qste_pkg::EXTRA_W-1:0] r6_extra;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int j = 0; j < 3; j++) begin
                r6_code[j] <= lane_code[j];
            end
            r6_idx   <= r5_idx;
            r6_sign  <= r5_sign;
            r6_main  <= n_main;
            r6_extra <= n_extra;
        end
    end

    assign o_out.code_first       = r6_code[0];
    assign o_out.code_second      = r6_code[1];
    assign o_out.code_third       = r6_code[2];
    assign o_out.dropped_index    = r6_idx;
    assign o_out.largest_positive = r6_sign;
    assign o_out.packed_main      = r6_main;
    assign o_out.packed_extra     = r6_extra;

endmodule
`default_nettype wire
